// ===== hdl/tmap_pkg.sv =====
// Shared types and constants for the trimmed-mean ADC to PWM map.
// Used by tmap_cfg, tmap_window, tmap_map and the top level.
`timescale 1ns / 1ps

package tmap_pkg;

    localparam int RAW_W    = 10;
    localparam int SAMPLE_W = 9;
    localparam int SUM_W    = 13;
    localparam int COUNT_W  = 4;
    localparam int SLOPE_W  = 24;
    localparam int FRAC_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [COUNT_W-1:0]  WINDOW_LAST = 4'd9;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 9'h1FF;

    // PWM levels before the scale shift.
    localparam logic [SAMPLE_W-1:0] PWM_MIN_BASE    = 9'h00F;
    localparam logic [SAMPLE_W-1:0] PWM_CENTER_BASE = 9'h07F;
    localparam logic [SAMPLE_W-1:0] PWM_MAX_BASE    = 9'h0F0;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_LOW_END    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_HIGH_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_SLOPE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_SLOPE    = 3'd5;

    typedef struct packed {
        logic [SAMPLE_W-1:0] adc_low_end;
        logic [SAMPLE_W-1:0] dead_band_low;
        logic [SAMPLE_W-1:0] dead_band_high;
        logic [SAMPLE_W-1:0] adc_high_end;
        logic [SLOPE_W-1:0]  upper_slope;
        logic [SLOPE_W-1:0]  lower_slope;
    } cfg_t;

endpackage

// ===== hdl/tmap_cfg.sv =====
// Configuration register file for the trimmed-mean PWM map.
// Depends on tmap_pkg for register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module tmap_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tmap_pkg::SLOPE_W-1:0]   cfg_data,
    output tmap_pkg::cfg_t                 cfg
);
    import tmap_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.adc_low_end    <= 9'd254;
            cfg_reg.dead_band_low  <= 9'd255;
            cfg_reg.dead_band_high <= 9'd256;
            cfg_reg.adc_high_end   <= 9'd257;
            cfg_reg.upper_slope    <= 24'd7405568;
            cfg_reg.lower_slope    <= 24'd7340032;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ADC_LOW_END:    cfg_reg.adc_low_end    <= cfg_data[SAMPLE_W-1:0];
                CFG_DEAD_BAND_LOW:  cfg_reg.dead_band_low  <= cfg_data[SAMPLE_W-1:0];
                CFG_DEAD_BAND_HIGH: cfg_reg.dead_band_high <= cfg_data[SAMPLE_W-1:0];
                CFG_ADC_HIGH_END:   cfg_reg.adc_high_end   <= cfg_data[SAMPLE_W-1:0];
                CFG_UPPER_SLOPE:    cfg_reg.upper_slope    <= cfg_data;
                CFG_LOWER_SLOPE:    cfg_reg.lower_slope    <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/tmap_window.sv =====
// Ten-sample window: running sum, min and max, trimmed average on the tenth.
// Depends on tmap_pkg for widths and the window length.
`timescale 1ns / 1ps

module tmap_window (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tmap_pkg::RAW_W-1:0]    in_raw,
    output logic                          avg_valid,
    input  logic                          avg_ready,
    output logic [tmap_pkg::SAMPLE_W-1:0] avg_value
);
    import tmap_pkg::*;

    logic [SUM_W-1:0]    sum_reg,   sum_next;
    logic [SAMPLE_W-1:0] low_reg,   low_next;
    logic [SAMPLE_W-1:0] high_reg,  high_next;
    logic [COUNT_W-1:0]  count_reg;
    logic                avg_valid_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [SAMPLE_W-1:0] sample;
    logic [SUM_W-1:0]    trimmed;
    logic                last;
    logic                take;

    assign sample    = in_raw[RAW_W-1:1];
    assign last      = (count_reg == WINDOW_LAST);
    // Only the closing sample needs room in the average register.
    assign in_ready  = !last || !avg_valid_reg || avg_ready;
    assign take      = in_valid && in_ready;
    assign sum_next  = sum_reg + SUM_W'(sample);
    assign low_next  = (sample < low_reg)  ? sample : low_reg;
    assign high_next = (sample > high_reg) ? sample : high_reg;
    assign trimmed   = sum_next - SUM_W'(low_next) - SUM_W'(high_next);

    assign avg_valid = avg_valid_reg;
    assign avg_value = avg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            low_reg       <= SAMPLE_MAX;
            high_reg      <= '0;
            count_reg     <= '0;
            avg_valid_reg <= 1'b0;
        end else begin
            if (avg_valid_reg && avg_ready) begin
                avg_valid_reg <= 1'b0;
            end
            if (take) begin
                if (last) begin
                    sum_reg       <= '0;
                    low_reg       <= SAMPLE_MAX;
                    high_reg      <= '0;
                    count_reg     <= '0;
                    avg_valid_reg <= 1'b1;
                end else begin
                    sum_reg   <= sum_next;
                    low_reg   <= low_next;
                    high_reg  <= high_next;
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && last) begin
            avg_reg <= trimmed[SAMPLE_W+2:3];
        end
    end

endmodule

// ===== hdl/tmap_map.sv =====
// Piecewise-linear map of the trimmed average to a PWM level, two stages:
// zone decode and slope product, then offset add, saturation and output hold.
// Depends on tmap_pkg for widths, levels and the cfg_t bundle.
`timescale 1ns / 1ps

module tmap_map #(
    parameter int PWM_SCALE_SHIFT = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tmap_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tmap_pkg::SAMPLE_W-1:0] in_avg,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tmap_pkg::SAMPLE_W-1:0] out_level,
    output logic [tmap_pkg::SAMPLE_W-1:0] out_avg
);
    import tmap_pkg::*;

    localparam logic [SAMPLE_W-1:0] LVL_MIN    = SAMPLE_W'(PWM_MIN_BASE << PWM_SCALE_SHIFT);
    localparam logic [SAMPLE_W-1:0] LVL_CENTER = SAMPLE_W'(PWM_CENTER_BASE << PWM_SCALE_SHIFT);
    localparam logic [SAMPLE_W-1:0] LVL_MAX    = SAMPLE_W'(PWM_MAX_BASE << PWM_SCALE_SHIFT);
    localparam int PROD_W = SLOPE_W + SAMPLE_W;
    localparam int HI_W   = PROD_W - FRAC_W;

    typedef enum logic [2:0] {
        ZONE_MAX,
        ZONE_UPPER,
        ZONE_CENTER,
        ZONE_LOWER,
        ZONE_MIN
    } zone_t;

    zone_t               zone_next, zone_reg;
    logic [SLOPE_W-1:0]  slope_sel;
    logic [SAMPLE_W-1:0] diff_sel;
    logic [PROD_W-1:0]   prod_full;
    logic [HI_W-1:0]     prod_reg;
    logic [SAMPLE_W-1:0] p_avg_reg;
    logic                p_valid_reg;
    logic                p_ready;

    logic [HI_W:0]       ramp_sum;
    logic [SAMPLE_W-1:0] ramp_base;
    logic [SAMPLE_W-1:0] ramp_sat;
    logic [SAMPLE_W-1:0] level_next;
    logic [SAMPLE_W-1:0] level_reg;
    logic [SAMPLE_W-1:0] o_avg_reg;
    logic                o_valid_reg;
    logic                o_ready;

    assign o_ready  = !o_valid_reg || out_ready;
    assign p_ready  = !p_valid_reg || o_ready;
    assign in_ready = p_ready;

    // Zone decode, tested in priority order.
    always_comb begin
        zone_next = ZONE_CENTER;
        slope_sel = '0;
        diff_sel  = '0;
        if (in_avg > cfg.dead_band_high) begin
            zone_next = (in_avg > cfg.adc_high_end) ? ZONE_MAX : ZONE_UPPER;
            slope_sel = cfg.upper_slope;
            diff_sel  = in_avg - cfg.dead_band_high;
        end else if (in_avg < cfg.dead_band_low) begin
            zone_next = (in_avg < cfg.adc_low_end) ? ZONE_MIN : ZONE_LOWER;
            slope_sel = cfg.lower_slope;
            diff_sel  = in_avg - cfg.adc_low_end;
        end
    end

    assign prod_full = PROD_W'(slope_sel) * PROD_W'(diff_sel);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (p_ready) begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_ready && in_valid) begin
            zone_reg  <= zone_next;
            prod_reg  <= prod_full[PROD_W-1:FRAC_W];
            p_avg_reg <= in_avg;
        end
    end

    // Offset, add and clamp to the 9-bit range.
    assign ramp_base = (zone_reg == ZONE_UPPER) ? LVL_CENTER : LVL_MIN;
    assign ramp_sum  = (HI_W + 1)'(ramp_base) + (HI_W + 1)'(prod_reg);
    assign ramp_sat  = (ramp_sum > (HI_W + 1)'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                            : ramp_sum[SAMPLE_W-1:0];

    always_comb begin
        case (zone_reg)
            ZONE_MAX:    level_next = LVL_MAX;
            ZONE_UPPER:  level_next = ramp_sat;
            ZONE_LOWER:  level_next = ramp_sat;
            ZONE_MIN:    level_next = LVL_MIN;
            default:     level_next = LVL_CENTER;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (o_ready) begin
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_ready && p_valid_reg) begin
            level_reg <= level_next;
            o_avg_reg <= p_avg_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_level = level_reg;
    assign out_avg   = o_avg_reg;

endmodule

// ===== hdl/trimmed_mean_adc_to_pwm_map_core.sv =====
// Top level of the trimmed-mean ADC to PWM map.
// Instantiates tmap_cfg, tmap_window and tmap_map; depends on tmap_pkg.
`timescale 1ns / 1ps

// Raw 10-bit converter samples arrive one per transfer on the s_ stream and
// lose their low bit. Every ten samples the block drops the smallest and the
// largest, averages the other eight (truncating divide by eight) and maps the
// average to a PWM compare value: minimum level below adc_low_end, a ramp of
// lower_slope from the minimum up to dead_band_low, the center level across
// the dead band, a ramp of upper_slope from the center above dead_band_high,
// and the maximum level above adc_high_end. Slopes are unsigned Q8.16; ramp
// products are truncated and the level clamps at 511. One result transfer
// on the m_ stream follows each tenth sample; other samples give none.
// Throughput is one sample per clock while s_tready stays high. After the tenth
// sample's transfer the result passes the window accumulator and trim, zone
// decode and the 24x9 slope multiply, then the offset add and clamp, each
// registered. A stalled result is held in the output register while further
// samples keep flowing into the next window; only a window's closing sample
// waits when all three stages hold results. Configuration writes are always
// accepted and must come while the block is idle. PWM_SCALE_SHIFT (0 or 1)
// doubles the minimum, center and maximum.

module trimmed_mean_adc_to_pwm_map_core #(
    parameter int PWM_SCALE_SHIFT = 0
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Sample stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // [9:0] raw_sample

    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // [8:0] pwm_level, [17:9] smoothed_value

    // Register writes.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tmap_pkg::SLOPE_W-1:0]   cfg_data
);
    import tmap_pkg::*;

    cfg_t                cfg;
    logic                avg_valid;
    logic                avg_ready;
    logic [SAMPLE_W-1:0] avg_value;
    logic [SAMPLE_W-1:0] pwm_level;
    logic [SAMPLE_W-1:0] smoothed_value;

    tmap_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Accumulate the window; emit the trimmed average on its tenth transfer.
    tmap_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_raw    (s_tdata[RAW_W-1:0]),
        .avg_valid (avg_valid),
        .avg_ready (avg_ready),
        .avg_value (avg_value)
    );

    // Map the average to a PWM level and hold it for the result transfer.
    tmap_map #(
        .PWM_SCALE_SHIFT (PWM_SCALE_SHIFT)
    ) u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (avg_valid),
        .in_ready  (avg_ready),
        .in_avg    (avg_value),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_level (pwm_level),
        .out_avg   (smoothed_value)
    );

    assign m_tdata = {6'd0, smoothed_value, pwm_level};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for trimmed_mean_adc_to_pwm_map_core.
// Drives sample and register streams, predicts each trimmed average and PWM level.
// Depends on tmap_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
    import tmap_pkg::*;

    localparam int SCALE_SHIFT     = 0;
    // Longest stretch with no transfer on any channel before the run is declared hung.
    // The deliberate receiver hold-off is the longest legal quiet stretch.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 400;
    // Settling pad after the last predicted result is back.
    localparam int DRAIN_PAD       = 8;
    localparam int MAX_REPORTS     = 10;
    localparam int N_ZONES         = 5;

    // Register indexes the block does not decode; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam logic [SAMPLE_W-1:0] LVL_MIN    = SAMPLE_W'(PWM_MIN_BASE << SCALE_SHIFT);
    localparam logic [SAMPLE_W-1:0] LVL_CENTER = SAMPLE_W'(PWM_CENTER_BASE << SCALE_SHIFT);
    localparam logic [SAMPLE_W-1:0] LVL_MAX    = SAMPLE_W'(PWM_MAX_BASE << SCALE_SHIFT);

    typedef enum int {
        ZONE_MAX,
        ZONE_UPPER,
        ZONE_CENTER,
        ZONE_LOWER,
        ZONE_MIN
    } zone_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pwm;
        logic [SAMPLE_W-1:0] avg;
    } level_pair_t;

    // Clock, reset and every block input start at known values.
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;   // [9:0] raw_sample
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;          // [8:0] pwm_level, [17:9] smoothed_value
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SLOPE_W-1:0]   cfg_data  = '0;

    always #4 aclk = ~aclk;

    trimmed_mean_adc_to_pwm_map_core #(
        .PWM_SCALE_SHIFT(SCALE_SHIFT)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: a private copy of the registers and the running window.
    cfg_t                cfg_model;
    logic [SUM_W-1:0]    win_sum;
    logic [SAMPLE_W-1:0] win_low;
    logic [SAMPLE_W-1:0] win_high;
    logic [COUNT_W-1:0]  win_count;

    logic [RAW_W-1:0] sample_q [$];   // raw samples waiting for the driver
    level_pair_t      level_q  [$];   // predicted results waiting for the monitor

    // Traffic shaping, written only by the sequencing block.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          pressure_on    = 1'b0;

    // Monitor-owned hold-off counter.
    int          hold_left = 0;
    bit          hold_used = 1'b0;

    int samples_sent    = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int error_count     = 0;
    int quiet_cycles    = 0;
    int zone_hits [N_ZONES];

    function automatic void report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endfunction

    function automatic void clear_window();
        win_sum   = '0;
        win_low   = SAMPLE_MAX;
        win_high  = '0;
        win_count = '0;
    endfunction

    // Five-zone map; the ramp difference is kept to nine bits, so inconsistent
    // registers wrap it just as the block does.
    function automatic logic [SAMPLE_W-1:0] map_average(input logic [SAMPLE_W-1:0] a,
                                                        output zone_t zone);
        logic [SAMPLE_W-1:0] diff;
        logic [63:0]         ramp;
        if (a > cfg_model.dead_band_high) begin
            if (a > cfg_model.adc_high_end) begin
                zone = ZONE_MAX;
                return LVL_MAX;
            end
            zone = ZONE_UPPER;
            diff = a - cfg_model.dead_band_high;
            ramp = 64'(LVL_CENTER) + ((64'(cfg_model.upper_slope) * 64'(diff)) >> FRAC_W);
        end else if (a < cfg_model.dead_band_low) begin
            if (a < cfg_model.adc_low_end) begin
                zone = ZONE_MIN;
                return LVL_MIN;
            end
            zone = ZONE_LOWER;
            diff = a - cfg_model.adc_low_end;
            ramp = 64'(LVL_MIN) + ((64'(cfg_model.lower_slope) * 64'(diff)) >> FRAC_W);
        end else begin
            zone = ZONE_CENTER;
            return LVL_CENTER;
        end
        // Clamp ramp overflow at the 9-bit ceiling.
        return (ramp > 64'(SAMPLE_MAX)) ? SAMPLE_MAX : ramp[SAMPLE_W-1:0];
    endfunction

    // Fold one accepted sample into the window; on the tenth, trim and queue a result.
    function automatic void accumulate_sample(input logic [RAW_W-1:0] raw);
        logic [SAMPLE_W-1:0] s;
        logic [SUM_W-1:0]    trimmed;
        level_pair_t         pair;
        zone_t               zone;
        s       = raw[RAW_W-1:1];
        win_sum = win_sum + SUM_W'(s);
        if (s < win_low)  win_low  = s;
        if (s > win_high) win_high = s;
        if (win_count != WINDOW_LAST) begin
            win_count++;
            return;
        end
        trimmed  = win_sum - SUM_W'(win_low) - SUM_W'(win_high);
        pair.avg = trimmed[SAMPLE_W+2:3];
        pair.pwm = map_average(pair.avg, zone);
        zone_hits[zone]++;
        level_q.push_back(pair);
        clear_window();
    endfunction

    // Sample driver: advance to the next pending sample when the slot is free and no random idle is drawn.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                accumulate_sample(s_tdata[RAW_W-1:0]);
                samples_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata  <= 16'(sample_q.pop_front());
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer against the oldest prediction.
    always @(posedge aclk) begin
        level_pair_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (level_q.size() == 0) begin
                    report_error($sformatf("unexpected result: pwm %0d avg %0d",
                                           m_tdata[8:0], m_tdata[17:9]));
                end else begin
                    want = level_q.pop_front();
                    if (m_tdata[8:0] !== want.pwm || m_tdata[17:9] !== want.avg) begin
                        report_error($sformatf("result mismatch: pwm %0d/%0d avg %0d/%0d",
                                               want.pwm, m_tdata[8:0],
                                               want.avg, m_tdata[17:9]));
                    end
                end
            end
            // Arm the one long hold-off when the pressure phase starts.
            if (pressure_on && !hold_used) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run if no channel moves a transfer for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("tb_top failed");
                    $finish;
                end
            end
        end
    end

    // Write one register and mirror it into the predictor once the transfer lands.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SLOPE_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_ADC_LOW_END:    cfg_model.adc_low_end    = value[SAMPLE_W-1:0];
            CFG_DEAD_BAND_LOW:  cfg_model.dead_band_low  = value[SAMPLE_W-1:0];
            CFG_DEAD_BAND_HIGH: cfg_model.dead_band_high = value[SAMPLE_W-1:0];
            CFG_ADC_HIGH_END:   cfg_model.adc_high_end   = value[SAMPLE_W-1:0];
            CFG_UPPER_SLOPE:    cfg_model.upper_slope    = value;
            CFG_LOWER_SLOPE:    cfg_model.lower_slope    = value;
            default: ;
        endcase
    endtask

    // Junk above bit 8 of a threshold must be ignored by the block.
    function automatic logic [SLOPE_W-1:0] pad_high_bits(input logic [SAMPLE_W-1:0] v);
        return {(SLOPE_W - SAMPLE_W)'($urandom), v};
    endfunction

    task automatic load_settings(input logic [SAMPLE_W-1:0] lo_end, input logic [SAMPLE_W-1:0] db_lo,
                                 input logic [SAMPLE_W-1:0] db_hi, input logic [SAMPLE_W-1:0] hi_end,
                                 input logic [SLOPE_W-1:0] up, input logic [SLOPE_W-1:0] dn);
        write_reg(CFG_ADC_LOW_END,    pad_high_bits(lo_end));
        write_reg(CFG_DEAD_BAND_LOW,  pad_high_bits(db_lo));
        write_reg(CFG_DEAD_BAND_HIGH, pad_high_bits(db_hi));
        write_reg(CFG_ADC_HIGH_END,   pad_high_bits(hi_end));
        write_reg(CFG_UPPER_SLOPE,    up);
        write_reg(CFG_LOWER_SLOPE,    dn);
    endtask

    // Hold until every sample is sent and every result is back, then let the
    // pipeline settle before the next register writes.
    task automatic wait_drained();
        while (sample_q.size() != 0 || s_tvalid || level_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    // One random phase: pick traffic shape and registers, then stream windows
    // of samples clustered around a threshold or a random point, with occasional outliers.
    task automatic run_phase(input int phase);
        int unsigned thr [$];
        int          n_items;
        int          center;
        int          s;
        int          pick;
        int          k;
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
        endcase
        for (k = 0; k < 4; k++) thr.push_back($urandom_range(0, SAMPLE_MAX));
        case (phase)
            1: load_settings(9'd254, 9'd255, 9'd256, 9'd257, 24'd7405568, 24'd7340032);
            3: load_settings('0, '0, '0, '0, {SLOPE_W{1'b1}}, {SLOPE_W{1'b1}});
            4: load_settings(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, '0, '0);
            5: begin
                // Steep ramps overflow; keep the sender busy and stall the receiver.
                thr.sort();
                load_settings(SAMPLE_W'(thr[0]), SAMPLE_W'(thr[1]),
                              SAMPLE_W'(thr[2]), SAMPLE_W'(thr[3]),
                              {SLOPE_W{1'b1}}, {SLOPE_W{1'b1}});
                send_idle_pct = 0;
                pressure_on   = 1'b1;
            end
            6: load_settings(SAMPLE_W'(thr[0]), SAMPLE_W'(thr[1]),
                             SAMPLE_W'(thr[2]), SAMPLE_W'(thr[3]),
                             SLOPE_W'($urandom), SLOPE_W'($urandom));
            default: begin
                thr.sort();
                load_settings(SAMPLE_W'(thr[0]), SAMPLE_W'(thr[1]),
                              SAMPLE_W'(thr[2]), SAMPLE_W'(thr[3]),
                              SLOPE_W'($urandom_range(0, 24'h3FFFFF)),
                              SLOPE_W'($urandom_range(0, 24'h3FFFFF)));
            end
        endcase
        if (phase == 8) begin
            write_reg(CFG_SPARE_A, SLOPE_W'($urandom));
            write_reg(CFG_SPARE_B, SLOPE_W'($urandom));
        end
        n_items = 100 + $urandom_range(0, 5);
        while (n_items > 0) begin
            pick = $urandom_range(0, 4);
            case (pick)
                0: center = cfg_model.adc_low_end;
                1: center = cfg_model.dead_band_low;
                2: center = cfg_model.dead_band_high;
                3: center = cfg_model.adc_high_end;
                default: center = $urandom_range(0, SAMPLE_MAX);
            endcase
            center = center + $urandom_range(0, 8) - 4;
            for (k = 0; k < 10 && n_items > 0; k++) begin
                if ($urandom_range(99) < 12) begin
                    sample_q.push_back(RAW_W'($urandom));
                end else begin
                    s = center + $urandom_range(0, 6) - 3;
                    if (s < 0) s = 0;
                    if (s > SAMPLE_MAX) s = SAMPLE_MAX;
                    sample_q.push_back({SAMPLE_W'(s), 1'($urandom)});
                end
                n_items--;
            end
        end
        wait_drained();
        pressure_on = 1'b0;
    endtask

    initial begin
        logic [RAW_W-1:0] directed_raw [30];
        int               p;
        // Full-scale window with one zero trimmed away, then the mirror image,
        // then alternating bit patterns as trimmed extremes around a ramp value.
        directed_raw = '{10'd0, 10'd1023, 10'd1022, 10'd1023, 10'd1023,
                         10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                         10'd1023, 10'd0, 10'd1, 10'd0, 10'd0,
                         10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
                         10'h2AA, 10'h155, 10'd514, 10'd515, 10'd514,
                         10'd515, 10'd514, 10'd515, 10'd514, 10'd515};
        cfg_model.adc_low_end    = 9'd254;
        cfg_model.dead_band_low  = 9'd255;
        cfg_model.dead_band_high = 9'd256;
        cfg_model.adc_high_end   = 9'd257;
        cfg_model.upper_slope    = 24'd7405568;
        cfg_model.lower_slope    = 24'd7340032;
        clear_window();
        foreach (zone_hits[i]) zone_hits[i] = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed windows on the reset register values, no idling.
        foreach (directed_raw[i]) sample_q.push_back(directed_raw[i]);
        wait_drained();

        for (p = 1; p <= 8; p++) run_phase(p);

        if (level_q.size() != 0) begin
            report_error($sformatf("%0d results never arrived", level_q.size()));
        end
        $display("Run covered %0d samples over 9 register settings, %0d results, %0d writes",
                 samples_sent, results_checked, reg_writes);
        $display("Zones reached: max %0d, upper ramp %0d, center %0d, lower ramp %0d, min %0d",
                 zone_hits[ZONE_MAX], zone_hits[ZONE_UPPER], zone_hits[ZONE_CENTER],
                 zone_hits[ZONE_LOWER], zone_hits[ZONE_MIN]);
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== trimmed_mean_adc_to_pwm_map_core.f =====
hdl/tmap_pkg.sv
hdl/tmap_cfg.sv
hdl/tmap_window.sv
hdl/tmap_map.sv
hdl/trimmed_mean_adc_to_pwm_map_core.sv
tb/tb_top.sv
